// ===== hdl/jpeg_zip_polyglot_lister_macros.svh =====
`ifndef JPEG_ZIP_POLYGLOT_LISTER_MACROS_SVH
`define JPEG_ZIP_POLYGLOT_LISTER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define JZPL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define JZPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/jzpl_pkg.sv =====
package jzpl_pkg;

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic KIND_NAME   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] STATUS_NOT_JPEG = 2'd0;
  localparam logic [1:0] STATUS_PLAIN    = 2'd1;
  localparam logic [1:0] STATUS_ARCHIVE  = 2'd2;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;

  localparam logic [7:0] SIG_BYTE [4] = '{8'h50, 8'h4B, 8'h03, 8'h04};

  localparam logic [9:0]  NAME_LIMIT_RESET = 10'd512;
  localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
  localparam logic [4:0]  HDR_LAST         = 5'd25;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic        name_last;
    logic [1:0]  status;
    logic [15:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic       is_end;
    logic [7:0] data_byte;
    logic       is_prefix;
    logic       is_soi;
    logic       is_eoi;
    logic [3:0] sig_eq;
  } cls_item_t;

endpackage

// ===== hdl/jzpl_fifo.sv =====
module jzpl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/jzpl_front.sv =====
module jzpl_front (
  input  logic                push_i,
  input  jzpl_pkg::in_item_t  item_i,
  input  logic                queue_full_i,
  output logic                queue_push_o,
  output jzpl_pkg::cls_item_t cls_o
);

  assign queue_push_o = push_i && !queue_full_i;

  always_comb begin
    cls_o.is_end    = (item_i.func == jzpl_pkg::FUNC_END);
    cls_o.data_byte = item_i.data_byte;
    cls_o.is_prefix = (item_i.data_byte == jzpl_pkg::MARK_PREFIX);
    cls_o.is_soi    = (item_i.data_byte == jzpl_pkg::MARK_SOI);
    cls_o.is_eoi    = (item_i.data_byte == jzpl_pkg::MARK_EOI);
    for (int i = 0; i < 4; i++) begin
      cls_o.sig_eq[i] = (item_i.data_byte == jzpl_pkg::SIG_BYTE[i]);
    end
  end

endmodule

// ===== hdl/jzpl_back.sv =====
module jzpl_back #(
  parameter int unsigned MAX_NAME = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [9:0]          cfg_data_i,
  input  logic                item_valid_i,
  input  jzpl_pkg::cls_item_t item_i,
  output logic                item_take_o,
  input  logic                res_full_i,
  output logic                res_valid_o,
  output jzpl_pkg::out_item_t res_o
);

  localparam int unsigned LW = $clog2(MAX_NAME + 1);

  typedef enum logic [3:0] {
    PH_SOI0,
    PH_SOI1,
    PH_EOI,
    PH_SIG,
    PH_HDR,
    PH_NAME,
    PH_SKIP,
    PH_DONE,
    PH_BAD
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [9:0]  name_limit_q;
  logic [1:0]  match_q, match_d;
  logic [4:0]  hdr_idx_q, hdr_idx_d;
  logic [31:0] packed_size_q, packed_size_d;
  logic [15:0] name_length_q, name_length_d;
  logic [15:0] extra_length_q, extra_length_d;
  logic [LW-1:0] name_idx_q, name_idx_d;
  logic [32:0] skip_left_q, skip_left_d;
  logic [15:0] count_q, count_d;

  logic [LW-1:0] lim, emit, idx_inc, sel_idx;
  logic          over;
  logic [15:0]   rest;
  logic [32:0]   skip_sum;
  logic          skip_done;
  logic          take;

  assign take        = item_valid_i && !res_full_i;
  assign item_take_o = take;

  always_comb begin
    if (name_limit_q == '0) begin
      lim = LW'(1);
    end else if (32'(name_limit_q) > MAX_NAME) begin
      lim = LW'(MAX_NAME);
    end else begin
      lim = LW'(name_limit_q);
    end
    emit     = (name_length_q < 16'(lim)) ? LW'(name_length_q) : lim;
    over     = (name_idx_q >= emit);
    idx_inc  = name_idx_q + 1'b1;
    sel_idx  = over ? name_idx_q : idx_inc;
    rest     = (name_length_q > 16'(sel_idx)) ? name_length_q - 16'(sel_idx) : '0;
    skip_sum = 33'(rest) + 33'(packed_size_q) + 33'(extra_length_q) + (over ? '1 : '0);
    skip_done = over ? (skip_sum == '0 || skip_sum == '1) : (skip_sum == '0);
  end

  always_comb begin
    phase_d        = phase_q;
    match_d        = match_q;
    hdr_idx_d      = hdr_idx_q;
    packed_size_d  = packed_size_q;
    name_length_d  = name_length_q;
    extra_length_d = extra_length_q;
    name_idx_d     = name_idx_q;
    skip_left_d    = skip_left_q;
    count_d        = count_q;
    res_valid_o    = 1'b0;
    res_o          = '0;

    if (take) begin
      if (item_i.is_end) begin
        res_valid_o       = 1'b1;
        res_o.kind        = jzpl_pkg::KIND_STATUS;
        res_o.entry_count = count_q;
        if (phase_q == PH_SOI0 || phase_q == PH_SOI1 || phase_q == PH_EOI ||
            phase_q == PH_BAD) begin
          res_o.status = jzpl_pkg::STATUS_NOT_JPEG;
        end else if (count_q != '0) begin
          res_o.status = jzpl_pkg::STATUS_ARCHIVE;
        end else begin
          res_o.status = jzpl_pkg::STATUS_PLAIN;
        end
        phase_d        = PH_SOI0;
        match_d        = '0;
        hdr_idx_d      = '0;
        packed_size_d  = '0;
        name_length_d  = '0;
        extra_length_d = '0;
        name_idx_d     = '0;
        skip_left_d    = '0;
        count_d        = '0;
      end else begin
        unique case (phase_q)
          PH_SOI0: begin
            phase_d = item_i.is_prefix ? PH_SOI1 : PH_BAD;
          end
          PH_SOI1: begin
            if (item_i.is_soi) begin
              phase_d = PH_EOI;
              match_d = '0;
            end else begin
              phase_d = PH_BAD;
            end
          end
          PH_EOI: begin
            if (match_q == 2'd1 && item_i.is_eoi) begin
              phase_d = PH_SIG;
              match_d = '0;
            end else begin
              match_d = item_i.is_prefix ? 2'd1 : 2'd0;
            end
          end
          PH_SIG: begin
            if (item_i.sig_eq[match_q]) begin
              if (match_q == 2'd3) begin
                match_d        = '0;
                hdr_idx_d      = '0;
                packed_size_d  = '0;
                name_length_d  = '0;
                extra_length_d = '0;
                phase_d        = PH_HDR;
              end else begin
                match_d = match_q + 1'b1;
              end
            end else begin
              match_d = item_i.sig_eq[0] ? 2'd1 : 2'd0;
            end
          end
          PH_HDR: begin
            case (hdr_idx_q)
              5'd14:   packed_size_d[7:0]    = item_i.data_byte;
              5'd15:   packed_size_d[15:8]   = item_i.data_byte;
              5'd16:   packed_size_d[23:16]  = item_i.data_byte;
              5'd17:   packed_size_d[31:24]  = item_i.data_byte;
              5'd22:   name_length_d[7:0]    = item_i.data_byte;
              5'd23:   name_length_d[15:8]   = item_i.data_byte;
              5'd24:   extra_length_d[7:0]   = item_i.data_byte;
              5'd25:   extra_length_d[15:8]  = item_i.data_byte;
              default: packed_size_d         = packed_size_q;
            endcase
            if (hdr_idx_q == jzpl_pkg::HDR_LAST) begin
              hdr_idx_d  = '0;
              name_idx_d = '0;
              phase_d    = (name_length_d == '0) ? PH_DONE : PH_NAME;
            end else begin
              hdr_idx_d = hdr_idx_q + 1'b1;
            end
          end
          PH_NAME: begin
            if (over) begin
              match_d     = '0;
              skip_left_d = skip_sum;
              phase_d     = skip_done ? PH_SIG : PH_SKIP;
            end else begin
              if (name_idx_q == '0 && count_q != jzpl_pkg::COUNT_MAX) begin
                count_d = count_q + 1'b1;
              end
              name_idx_d      = idx_inc;
              res_valid_o     = 1'b1;
              res_o.kind      = jzpl_pkg::KIND_NAME;
              res_o.name_byte = item_i.data_byte;
              res_o.name_last = (idx_inc == emit);
              if (idx_inc == emit) begin
                match_d     = '0;
                skip_left_d = skip_sum;
                phase_d     = skip_done ? PH_SIG : PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            if (skip_left_q == 33'd1) begin
              skip_left_d = '0;
              phase_d     = PH_SIG;
              match_d     = '0;
            end else begin
              skip_left_d = skip_left_q - 1'b1;
            end
          end
          PH_DONE, PH_BAD: begin
            phase_d = phase_q;
          end
          default: begin
            phase_d = PH_BAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_SOI0;
      name_limit_q   <= jzpl_pkg::NAME_LIMIT_RESET;
      match_q        <= '0;
      hdr_idx_q      <= '0;
      packed_size_q  <= '0;
      name_length_q  <= '0;
      extra_length_q <= '0;
      name_idx_q     <= '0;
      skip_left_q    <= '0;
      count_q        <= '0;
    end else begin
      phase_q        <= phase_d;
      if (cfg_valid_i) begin
        name_limit_q <= cfg_data_i;
      end
      match_q        <= match_d;
      hdr_idx_q      <= hdr_idx_d;
      packed_size_q  <= packed_size_d;
      name_length_q  <= name_length_d;
      extra_length_q <= extra_length_d;
      name_idx_q     <= name_idx_d;
      skip_left_q    <= skip_left_d;
      count_q        <= count_d;
    end
  end

endmodule

// ===== hdl/jpeg_zip_polyglot_lister.sv =====
// channel   direction  handshake                 payload
// input     in         push / full               in_i   (func, data_byte)
// result    out        pop / empty               out_o  (kind, name_byte, name_last,
//                                                        status, entry_count)
// config    in         cfg_valid_i / cfg_ready_o cfg_data_i (name_limit)
//
// One byte or end item per cycle sustained while full is low; a result reaches
// out_o through the classify queue and then the result queue, both registered.
// Reset clears both queues, the parse state and sets name_limit to 512.
// full rises only when the result side stalls long enough to back up both queues.
// cfg_ready_o is always high; each transfer on it takes effect in the next cycle.
module jpeg_zip_polyglot_lister #(
  parameter int unsigned MAX_NAME    = 512,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  jzpl_pkg::in_item_t  in_i,
  output logic                empty,
  input  logic                pop,
  output jzpl_pkg::out_item_t out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [9:0]          cfg_data_i
);

  jzpl_pkg::cls_item_t cls_in, cls_out;
  jzpl_pkg::out_item_t res;
  logic                cls_push, cls_empty, cls_take;
  logic                res_valid, res_full;

  assign cfg_ready_o = 1'b1;

  jzpl_front u_front (
    .push_i       (push),
    .item_i       (in_i),
    .queue_full_i (full),
    .queue_push_o (cls_push),
    .cls_o        (cls_in)
  );

  jzpl_fifo #(
    .WIDTH ($bits(jzpl_pkg::cls_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cls_push),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (cls_take),
    .data_o  (cls_out),
    .empty_o (cls_empty)
  );

  jzpl_back #(
    .MAX_NAME (MAX_NAME)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (!cls_empty),
    .item_i       (cls_out),
    .item_take_o  (cls_take),
    .res_full_i   (res_full),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  jzpl_fifo #(
    .WIDTH ($bits(jzpl_pkg::out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_o),
    .empty_o (empty)
  );

endmodule

// ===== hdl/jzpl_checker.sv =====
`include "jpeg_zip_polyglot_lister_macros.svh"

module jzpl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input jzpl_pkg::out_item_t out_o
);

  logic status_shown, name_shown;

  assign status_shown = !empty && (out_o.kind == jzpl_pkg::KIND_STATUS);
  assign name_shown   = !empty && (out_o.kind == jzpl_pkg::KIND_NAME);

  `JZPL_ASSERT_NOW(a_status_code, status_shown, out_o.status != 2'd3, "bad status code")
  `JZPL_ASSERT_NOW(a_archive_count, status_shown,
    (out_o.status == jzpl_pkg::STATUS_ARCHIVE) == (out_o.entry_count != '0),
    "status and entry count disagree")
  `JZPL_ASSERT_NOW(a_name_clean, name_shown,
    out_o.status == jzpl_pkg::STATUS_NOT_JPEG && out_o.entry_count == '0,
    "name transfer carries status fields")
  `JZPL_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(out_o),
    "stalled result changed")

endmodule

bind jpeg_zip_polyglot_lister jzpl_checker u_jzpl_checker (.*);
